FILE: hdl/text_console_cursor_renderer_macros.svh
// ----------------------------------------------------------------------------
// Text console cursor renderer - assertion macros
// Concurrent checks on clk_i, masked while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_RENDERER_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_RENDERER_MACROS_SVH

`ifndef SYNTHESIS

`define TCCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define TCCR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TCCR_ASSERT(lbl, prop, msg)
`define TCCR_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: hdl/tccr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor renderer - package
// Sizes, character codes, command codes and shared types.
// ----------------------------------------------------------------------------
package tccr_pkg;

  localparam int MaxColumns = 512;
  localparam int MaxRows    = 256;
  localparam int GlyphLines = 16;
  localparam int GlyphCount = 128;
  localparam int StoreDepth = GlyphCount * GlyphLines;

  localparam int ColW   = 10;
  localparam int RowW   = 8;
  localparam int ColsW  = 10;
  localparam int RowsW  = 9;
  localparam int PixW   = 12;
  localparam int ByteW  = 8;
  localparam int LineW  = $clog2(GlyphLines);
  localparam int GlyphW = $clog2(GlyphCount);
  localparam int AddrW  = $clog2(StoreDepth);
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = ColsW;

  localparam logic [CfgIdxW-1:0] RegTextColumns = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTextRows    = CfgIdxW'(1);

  localparam logic [ColsW-1:0] ColsReset = ColsW'(80);
  localparam logic [RowsW-1:0] RowsReset = RowsW'(25);

  localparam logic CmdChar = 1'b0;
  localparam logic CmdFont = 1'b1;

  localparam logic KindGlyph  = 1'b0;
  localparam logic KindScroll = 1'b1;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChBel     = 8'h07;
  localparam logic [7:0] ChBs      = 8'h08;
  localparam logic [7:0] ChHt      = 8'h09;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChVt      = 8'h0B;
  localparam logic [7:0] ChFf      = 8'h0C;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChHighest = 8'h7F;

  typedef enum logic [1:0] {
    StIdle,
    StDraw,
    StScroll
  } seq_state_e;

  // Work handed from the cursor logic to the sequencer when a character lands.
  typedef struct packed {
    logic              draw;
    logic              scroll;
    logic [GlyphW-1:0] glyph;
    logic [PixW-1:0]   cell_x;
    logic [PixW-1:0]   cell_y;
  } job_t;

endpackage

FILE: hdl/tccr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor renderer - input channel
// Character and font-load beats, valid/ready.
// ----------------------------------------------------------------------------
interface tccr_in_if
  import tccr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             command;
  logic [7:0]       char_code;
  logic [AddrW-1:0] font_index;
  logic [ByteW-1:0] font_byte;

  modport source (output valid, command, char_code, font_index, font_byte, input ready);
  modport sink   (input valid, command, char_code, font_index, font_byte, output ready);
endinterface

FILE: hdl/tccr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor renderer - result channel
// Glyph-row and scroll beats, valid/ready.
// ----------------------------------------------------------------------------
interface tccr_out_if
  import tccr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [PixW-1:0]  pixel_x;
  logic [PixW-1:0]  pixel_y;
  logic [ByteW-1:0] row_bits;
  logic             last_result;

  modport source (output valid, result_kind, pixel_x, pixel_y, row_bits, last_result,
                  input ready);
  modport sink   (input valid, result_kind, pixel_x, pixel_y, row_bits, last_result,
                  output ready);
endinterface

FILE: hdl/tccr_font_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor renderer - glyph store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tccr_font_ram #(
  parameter int Depth = 2048,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tccr_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor renderer - cursor and geometry
// Holds the size registers and the cursor; decodes a character into a job.
// ----------------------------------------------------------------------------
module tccr_cursor
  import tccr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                acc_i,
  input  logic [7:0]          char_code_i,
  output job_t                job_o
);

  logic [ColsW-1:0] text_cols_q;
  logic [RowsW-1:0] text_rows_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;

  logic [ColsW-1:0] cols_eff;
  logic [RowsW-1:0] rows_eff;
  logic [ColW:0]    col_inc;
  logic [ColW:0]    col_tab;
  logic             row_room;
  logic [ColW-1:0]  draw_col;
  logic [RowW-1:0]  draw_row;
  logic [7:0]       glyph_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_cols_q <= ColsReset;
      text_rows_q <= RowsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTextColumns: text_cols_q <= cfg_wdata_i[ColsW-1:0];
        RegTextRows:    text_rows_q <= cfg_wdata_i[RowsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (text_cols_q == '0) begin
      cols_eff = ColsW'(1);
    end else if (text_cols_q > ColsW'(MaxColumns)) begin
      cols_eff = ColsW'(MaxColumns);
    end else begin
      cols_eff = text_cols_q;
    end
    if (text_rows_q == '0) begin
      rows_eff = RowsW'(1);
    end else if (text_rows_q > RowsW'(MaxRows)) begin
      rows_eff = RowsW'(MaxRows);
    end else begin
      rows_eff = text_rows_q;
    end
  end

  assign col_inc  = {1'b0, col_q} + (ColW+1)'(1);
  assign col_tab  = ({1'b0, col_q} | (ColW+1)'(3)) + (ColW+1)'(1);
  assign row_room = (RowsW'(row_q) + RowsW'(1)) < rows_eff;

  // Codes outside the printable range draw as a space.
  assign glyph_code = (char_code_i < ChSpace || char_code_i > ChHighest) ? ChSpace
                                                                         : char_code_i;

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    draw_col     = col_q;
    draw_row     = row_q;
    job_o.draw   = 1'b0;
    job_o.scroll = 1'b0;
    job_o.glyph  = glyph_code[GlyphW-1:0];
    unique case (char_code_i)
      ChNul, ChBel, ChFf: ;
      ChBs: begin
        if (col_q != '0) begin
          col_d      = col_q - ColW'(1);
          job_o.draw = 1'b1;
        end else if (row_q != '0) begin
          row_d      = row_q - RowW'(1);
          col_d      = ColW'(cols_eff - ColsW'(1));
          job_o.draw = 1'b1;
        end
        draw_col    = col_d;
        draw_row    = row_d;
        job_o.glyph = ChSpace[GlyphW-1:0];
      end
      ChHt: begin
        if (col_tab >= {1'b0, cols_eff}) begin
          col_d = '0;
          if (row_room) begin
            row_d = row_q + RowW'(1);
          end else begin
            job_o.scroll = 1'b1;
          end
        end else begin
          col_d = col_tab[ColW-1:0];
        end
      end
      ChLf, ChVt: begin
        if (row_room) begin
          row_d = row_q + RowW'(1);
        end else begin
          job_o.scroll = 1'b1;
        end
      end
      ChCr: col_d = '0;
      default: begin
        job_o.draw = 1'b1;
        if (col_inc >= {1'b0, cols_eff}) begin
          col_d = '0;
          if (row_room) begin
            row_d = row_q + RowW'(1);
          end else begin
            job_o.scroll = 1'b1;
          end
        end else begin
          col_d = col_inc[ColW-1:0];
        end
      end
    endcase
    job_o.cell_x = PixW'({draw_col, 3'b000});
    job_o.cell_y = PixW'({draw_row, {LineW{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: hdl/tccr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor renderer - row sequencer
// Steps through glyph rows on the store read port, then a scroll beat when the job scrolls;
// a read stage and an output register carry results to the channel.
// ----------------------------------------------------------------------------
`include "text_console_cursor_renderer_macros.svh"

module tccr_seq
  import tccr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  tccr_in_if.sink          in_i,
  tccr_out_if.source       out_o,
  input  job_t             job_i,
  output logic             acc_char_o,
  output logic             ram_we_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [ByteW-1:0] ram_rdata_i
);

  seq_state_e state_q, state_d;
  logic [LineW-1:0] line_q;
  job_t             job_q;

  logic             accept;
  logic             issue;
  logic             s1_take;
  logic             last_line;

  logic             s1_v_q;
  logic             s1_kind_q;
  logic             s1_last_q;
  logic [PixW-1:0]  s1_x_q;
  logic [PixW-1:0]  s1_y_q;
  logic             s1_kind_d;
  logic             s1_last_d;
  logic [PixW-1:0]  s1_x_d;
  logic [PixW-1:0]  s1_y_d;

  logic             out_v_q;
  logic             out_kind_q;
  logic             out_last_q;
  logic [PixW-1:0]  out_x_q;
  logic [PixW-1:0]  out_y_q;
  logic [ByteW-1:0] out_bits_q;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign acc_char_o = accept && (in_i.command == CmdChar);
  assign ram_we_o   = accept && (in_i.command == CmdFont);

  assign s1_take   = s1_v_q && (!out_v_q || out_o.ready);
  assign issue     = (state_q != StIdle) && (!s1_v_q || s1_take);
  assign last_line = (line_q == LineW'(GlyphLines - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (acc_char_o) begin
          if (job_i.draw) begin
            state_d = StDraw;
          end else if (job_i.scroll) begin
            state_d = StScroll;
          end
        end
      end
      StDraw: begin
        if (issue && last_line) begin
          state_d = job_q.scroll ? StScroll : StIdle;
        end
      end
      StScroll: begin
        if (issue) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ram_re_o    = issue && (state_q == StDraw);
    ram_raddr_o = {job_q.glyph, line_q};
    if (state_q == StScroll) begin
      s1_kind_d = KindScroll;
      s1_last_d = 1'b1;
      s1_x_d    = '0;
      s1_y_d    = '0;
    end else begin
      s1_kind_d = KindGlyph;
      s1_last_d = last_line && !job_q.scroll;
      s1_x_d    = job_q.cell_x;
      s1_y_d    = job_q.cell_y + PixW'(line_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      line_q  <= '0;
    end else begin
      state_q <= state_d;
      if (ram_re_o) begin
        line_q <= line_q + LineW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_char_o) begin
      job_q <= job_i;
    end
  end

  // Read stage: tags ride alongside the store's registered read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (issue) begin
      s1_v_q <= 1'b1;
    end else if (s1_take) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_kind_q <= s1_kind_d;
      s1_last_q <= s1_last_d;
      s1_x_q    <= s1_x_d;
      s1_y_q    <= s1_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_take) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      out_kind_q <= s1_kind_q;
      out_last_q <= s1_last_q;
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_bits_q <= (s1_kind_q == KindScroll) ? '0 : ram_rdata_i;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.last_result = out_last_q;
  assign out_o.pixel_x     = out_x_q;
  assign out_o.pixel_y     = out_y_q;
  assign out_o.row_bits    = out_bits_q;

  `TCCR_ASSERT(a_idle_line_zero, (state_q == StIdle) |-> (line_q == '0), "row count not home")
  `TCCR_ASSERT(a_idle_tail_last, (state_q == StIdle && s1_v_q) |-> s1_last_q, "beat left behind")
  `TCCR_ASSERT(a_draw_starts, (acc_char_o && job_i.draw) |=> (state_q == StDraw), "no draw")
  `TCCR_ASSERT_NEVER(a_scroll_blank, out_v_q && out_kind_q == KindScroll && (out_bits_q != '0 || out_x_q != '0 || out_y_q != '0), "scroll beat carries data")

endmodule

FILE: hdl/text_console_cursor_renderer.sv
`timescale 1ns / 1ps
// The first result beat passes the state register, the read stage and the output register
// after a character is accepted. A drawn character occupies the row sequencer for one store
// read per glyph row, plus a scroll beat when it scrolls; controls and font writes leave the
// sequencer idle unless the cursor scrolls; output stalls hold the sequencer.
// Reset clears the cursor and sets 80 columns by 25 rows; the glyph store is not cleared.
// ----------------------------------------------------------------------------
// Text console cursor renderer - top level
// Cursor control, glyph store and glyph-row sequencer for an 8x16 text console.
// ----------------------------------------------------------------------------
module text_console_cursor_renderer
  import tccr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  tccr_in_if.sink             in_i,
  tccr_out_if.source          out_o
);

  job_t             job;
  logic             acc_char;
  logic             ram_we;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  tccr_cursor u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc_char),
    .char_code_i (in_i.char_code),
    .job_o       (job)
  );

  tccr_font_ram #(
    .Depth (StoreDepth),
    .Width (ByteW)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.font_index),
    .wdata_i (in_i.font_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tccr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .job_i       (job),
    .acc_char_o  (acc_char),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule
